FILE: rtl/i2cmbs_pkg.sv
// Shared constants, codes and types for the I2C master byte sequencer.
package i2cmbs_pkg;

    // Default transmit buffer depth
    localparam int TX_DEPTH_DEF = 32;

    // Field widths
    localparam int IDX_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 6;
    localparam int BITS_W  = 4;
    localparam int CFG_I_W = 2;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;
    localparam int OUT_U_W = 2;

    // Input operation codes
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_I_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_I_W-1:0] CFG_TX_MODE    = 2'd1;
    localparam logic [CFG_I_W-1:0] CFG_BYTE_TOTAL = 2'd2;
    localparam logic [CFG_I_W-1:0] CFG_REP_START  = 2'd3;

    // Sequencer phase codes
    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_ADDR_ACK  = 3'd1;
    localparam logic [2:0] PH_CHECK     = 3'd2;
    localparam logic [2:0] PH_RX_ACK    = 3'd3;
    localparam logic [2:0] PH_PREP_STOP = 3'd4;
    localparam logic [2:0] PH_TX_ACK    = 3'd5;
    localparam logic [2:0] PH_TX_CHECK  = 3'd6;
    localparam logic [2:0] PH_STOP      = 3'd7;

    // Fixed shift values
    localparam logic [BYTE_W-1:0] SV_RELEASE = 8'hFF;
    localparam logic [BYTE_W-1:0] SV_LOW     = 8'h00;
    localparam logic [BITS_W-1:0] BITS_BYTE  = 4'd8;
    localparam logic [BITS_W-1:0] BITS_ONE   = 4'd1;
    localparam logic [BITS_W-1:0] BITS_NONE  = 4'd0;

    // One result word
    typedef struct packed {
        logic               done_res;
        logic               address_nack;
        logic               rx_valid;
        logic [BYTE_W-1:0]  rx_byte;
        logic               stop_pulse;
        logic               start_pulse;
        logic               sda_output;
        logic [BITS_W-1:0]  bit_count;
        logic               shift_write;
        logic [BYTE_W-1:0]  shift_value;
    } t_result;

endpackage

FILE: rtl/i2c_master_byte_sequencer.sv
// Top level of the I2C master byte sequencer: phase control, transmit buffer, output stage.
// A finish word's result word is registered, into the skid register when the output is held.
// Throughput: one input word per cycle while tready is high; a store word gives no result word.
// An output register plus a skid register decouple the sides; input stalls only when both hold.
// The transmit buffer is a memory with registered read, prefetched at the next send pointer.
// Synchronous active-low reset clears phase, counters, SDA drive and valid flags, sets config
// to defaults (slave address 66, others 0); buffer contents stay undefined until written.
module i2c_master_byte_sequencer #(
    parameter int TX_DEPTH = i2cmbs_pkg::TX_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: tx_index[4:0], tx_data[12:5], shift_in[20:13], zero pad[23:21]
    input  logic [i2cmbs_pkg::IN_W-1:0]   i_s_axis_tdata,
    // tuser: operation[0]
    input  logic                          i_s_axis_tuser,
    // Result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: shift_value[7:0], bit_count[11:8], sda_output[12], start_pulse[13],
    //        stop_pulse[14], rx_byte[22:15], address_nack[23], done_res[24], zero pad[31:25]
    output logic [i2cmbs_pkg::OUT_W-1:0]  o_m_axis_tdata,
    // tuser: shift_write[0], rx_valid[1]
    output logic [i2cmbs_pkg::OUT_U_W-1:0] o_m_axis_tuser,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [i2cmbs_pkg::CFG_I_W-1:0] i_cfg_index,
    input  logic [i2cmbs_pkg::BYTE_W-1:0] i_cfg_data
);
    import i2cmbs_pkg::*;

    localparam int PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TX_DEPTH - 1);

    // Configuration registers
    logic [BYTE_W-1:0] r_slave_addr;
    logic              r_tx_mode;
    logic [CNT_W-1:0]  r_byte_total;
    logic              r_rep_start;

    // Sequencer state
    logic [2:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_byte_count, n_byte_count;
    logic [PTR_W-1:0]  r_send_ptr, n_send_ptr;
    logic              r_drive, n_drive;

    // Transmit buffer and prefetched read word
    logic [BYTE_W-1:0] r_tx_mem [TX_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic [PTR_W-1:0]  rd_addr;

    // Output stage
    logic              r_out_valid, r_skid_valid;
    t_result           r_out, r_skid;
    t_result           res;

    // Unpacked input fields
    logic              in_op;
    logic [IDX_W-1:0]  in_idx;
    logic [BYTE_W-1:0] in_data;
    logic [BYTE_W-1:0] in_shift;
    logic              s_fire, fin_fire, store_fire, out_fire;
    logic [PTR_W-1:0]  ptr_inc;
    logic [CNT_W:0]    rx_need;

    assign in_op    = i_s_axis_tuser;
    assign in_idx   = i_s_axis_tdata[4:0];
    assign in_data  = i_s_axis_tdata[12:5];
    assign in_shift = i_s_axis_tdata[20:13];

    assign o_s_axis_tready = !r_skid_valid;
    assign o_cfg_ready     = 1'b1;
    assign s_fire     = i_s_axis_tvalid && o_s_axis_tready;
    assign fin_fire   = s_fire && (in_op == OP_FINISH);
    assign store_fire = s_fire && (in_op == OP_STORE) && (32'(in_idx) < 32'(TX_DEPTH));
    assign out_fire   = r_out_valid && i_m_axis_tready;

    assign ptr_inc = (r_send_ptr == PTR_LAST) ? '0 : r_send_ptr + 1'b1;
    assign rx_need = {1'b0, r_byte_count} + 7'd2;

    // Step the phase machine for one finish word
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_send_ptr   = r_send_ptr;
        n_drive      = r_drive;
        res          = '0;
        case (r_phase)
            PH_START: begin
                n_byte_count    = '0;
                n_send_ptr      = '0;
                res.start_pulse = 1'b1;
                n_drive         = 1'b1;
                res.shift_value = r_slave_addr;
                res.shift_write = 1'b1;
                res.bit_count   = BITS_BYTE;
                n_phase         = PH_ADDR_ACK;
            end
            PH_ADDR_ACK: begin
                n_drive       = 1'b0;
                res.bit_count = BITS_ONE;
                n_phase       = PH_CHECK;
            end
            PH_CHECK: begin
                if (in_shift[0]) begin
                    res.address_nack = 1'b1;
                    n_drive          = 1'b1;
                    res.shift_value  = SV_LOW;
                    res.shift_write  = 1'b1;
                    res.bit_count    = BITS_ONE;
                    n_phase          = r_tx_mode ? PH_STOP : PH_PREP_STOP;
                end else if (r_tx_mode) begin
                    n_drive         = 1'b1;
                    res.shift_value = r_rd_data;
                    res.shift_write = 1'b1;
                    res.bit_count   = BITS_BYTE;
                    n_send_ptr      = ptr_inc;
                    n_byte_count    = r_byte_count + 1'b1;
                    n_phase         = PH_TX_ACK;
                end else begin
                    n_drive       = 1'b0;
                    res.bit_count = BITS_BYTE;
                    n_phase       = PH_RX_ACK;
                end
            end
            PH_RX_ACK: begin
                res.rx_byte     = in_shift;
                res.rx_valid    = 1'b1;
                n_drive         = 1'b1;
                res.shift_write = 1'b1;
                res.bit_count   = BITS_ONE;
                // ACK all data bytes but the last, which gets NACK
                if (rx_need <= {1'b0, r_byte_total}) begin
                    res.shift_value = SV_LOW;
                    n_byte_count    = r_byte_count + 1'b1;
                    n_phase         = PH_CHECK;
                end else begin
                    res.shift_value = SV_RELEASE;
                    n_phase         = PH_PREP_STOP;
                end
            end
            PH_PREP_STOP: begin
                n_drive         = 1'b1;
                res.shift_value = SV_LOW;
                res.shift_write = 1'b1;
                res.bit_count   = BITS_ONE;
                n_phase         = PH_STOP;
            end
            PH_TX_ACK: begin
                n_drive       = 1'b0;
                res.bit_count = BITS_ONE;
                n_phase       = PH_TX_CHECK;
            end
            PH_TX_CHECK: begin
                n_drive         = 1'b1;
                res.shift_write = 1'b1;
                if (r_byte_count == r_byte_total) begin
                    res.shift_value = r_rep_start ? SV_RELEASE : SV_LOW;
                    res.bit_count   = BITS_ONE;
                    n_phase         = PH_STOP;
                end else begin
                    res.shift_value = r_rd_data;
                    res.bit_count   = BITS_BYTE;
                    n_send_ptr      = ptr_inc;
                    n_byte_count    = r_byte_count + 1'b1;
                    n_phase         = PH_TX_ACK;
                end
            end
            default: begin
                res.shift_value = SV_RELEASE;
                res.shift_write = 1'b1;
                res.bit_count   = BITS_NONE;
                res.stop_pulse  = 1'b1;
                n_drive         = 1'b0;
                res.done_res    = 1'b1;
                n_phase         = PH_START;
            end
        endcase
        res.sda_output = n_drive;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= 8'd66;
            r_tx_mode    <= 1'b0;
            r_byte_total <= '0;
            r_rep_start  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data;
                CFG_TX_MODE:    r_tx_mode    <= i_cfg_data[0];
                CFG_BYTE_TOTAL: r_byte_total <= i_cfg_data[CNT_W-1:0];
                CFG_REP_START:  r_rep_start  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance sequencer state on each finish word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_byte_count <= '0;
            r_send_ptr   <= '0;
            r_drive      <= 1'b0;
        end else if (fin_fire) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_send_ptr   <= n_send_ptr;
            r_drive      <= n_drive;
        end
    end

    // Transmit buffer: write stores, prefetch the word at the next send pointer
    assign rd_addr = !i_rst_n ? '0 : (fin_fire ? n_send_ptr : r_send_ptr);

    always_ff @(posedge i_clk) begin
        if (store_fire) begin
            r_tx_mem[PTR_W'(in_idx)] <= in_data;
        end
        if (store_fire && (PTR_W'(in_idx) == rd_addr)) begin
            r_rd_data <= in_data;
        end else begin
            r_rd_data <= r_tx_mem[rd_addr];
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (fin_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (fin_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.done_res, r_out.address_nack, r_out.rx_byte,
                              r_out.stop_pulse, r_out.start_pulse, r_out.sda_output,
                              r_out.bit_count, r_out.shift_value};
    assign o_m_axis_tuser  = {r_out.rx_valid, r_out.shift_write};

    // Skid stage only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // A finish word in the stop phase returns the sequencer to idle
    a_stop_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_fire && r_phase == PH_STOP) |=> (r_phase == PH_START && !r_drive))
        else $error("stop phase did not return to idle");

    // Start pulse always comes with a full address byte load
    a_start_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.start_pulse) |->
            (r_out.bit_count == BITS_BYTE && r_out.shift_write && r_out.sda_output))
        else $error("start pulse without address byte load");

    // Done marks the stop pulse and a released bus
    a_done_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |->
            (r_out.stop_pulse && !r_out.sda_output && r_out.bit_count == BITS_NONE))
        else $error("done without stop");

    // Store words never move the sequencer
    a_store_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && in_op == OP_STORE) |=> ($stable(r_phase) && $stable(r_byte_count)))
        else $error("store word changed sequencer state");

endmodule

FILE: tb/i2cmbs_checker.sv
`timescale 1ns / 100ps
// Checker for the I2C master byte sequencer: tracks sequencer state and compares result words.
module i2cmbs_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_valid,
    input  logic                           i_s_ready,
    input  logic [i2cmbs_pkg::IN_W-1:0]    i_s_data,
    input  logic                           i_s_user,
    input  logic                           i_m_valid,
    input  logic                           i_m_ready,
    input  logic [i2cmbs_pkg::OUT_W-1:0]   i_m_data,
    input  logic [i2cmbs_pkg::OUT_U_W-1:0] i_m_user,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [i2cmbs_pkg::CFG_I_W-1:0] i_cfg_index,
    input  logic [i2cmbs_pkg::BYTE_W-1:0]  i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output logic                           o_seq_idle
);
    import i2cmbs_pkg::*;

    localparam int DEPTH = TX_DEPTH_DEF;

    // Shadow copy of the configuration registers
    logic [BYTE_W-1:0] cfg_addr;
    logic              cfg_tx;
    logic [CNT_W-1:0]  cfg_total;
    logic              cfg_rs;

    // Shadow copy of the sequencer state
    logic [2:0]        phase = PH_START;
    logic [CNT_W-1:0]  byte_cnt;
    logic [IDX_W-1:0]  send_ptr;
    logic              drive_en;
    logic [BYTE_W-1:0] tx_buf [DEPTH];

    t_result expected_cmds[$];
    int      fails    = 0;
    int      reported = 0;

    // Fetch the byte at the send pointer and advance it, wrapping at the buffer end
    function automatic logic [BYTE_W-1:0] pop_tx_byte();
        logic [BYTE_W-1:0] v;
        v = tx_buf[send_ptr];
        send_ptr = (int'(send_ptr) + 1 >= DEPTH) ? '0 : send_ptr + 1'b1;
        return v;
    endfunction

    // Work out the shifter command for one finish report and advance the phase
    function automatic t_result next_command(logic [BYTE_W-1:0] sin);
        t_result r;
        r = '0;
        case (phase)
            PH_START: begin
                byte_cnt      = '0;
                send_ptr      = '0;
                r.start_pulse = 1'b1;
                drive_en      = 1'b1;
                r.shift_value = cfg_addr;
                r.shift_write = 1'b1;
                r.bit_count   = BITS_BYTE;
                phase         = PH_ADDR_ACK;
            end
            PH_ADDR_ACK: begin
                drive_en    = 1'b0;
                r.bit_count = BITS_ONE;
                phase       = PH_CHECK;
            end
            PH_CHECK: begin
                if (sin[0]) begin
                    // slave NACK: head for the stop
                    r.address_nack = 1'b1;
                    drive_en       = 1'b1;
                    r.shift_value  = SV_LOW;
                    r.shift_write  = 1'b1;
                    r.bit_count    = BITS_ONE;
                    phase          = cfg_tx ? PH_STOP : PH_PREP_STOP;
                end else if (cfg_tx) begin
                    drive_en      = 1'b1;
                    r.shift_value = pop_tx_byte();
                    r.shift_write = 1'b1;
                    r.bit_count   = BITS_BYTE;
                    byte_cnt      = byte_cnt + 1'b1;
                    phase         = PH_TX_ACK;
                end else begin
                    drive_en    = 1'b0;
                    r.bit_count = BITS_BYTE;
                    phase       = PH_RX_ACK;
                end
            end
            PH_RX_ACK: begin
                r.rx_byte  = sin;
                r.rx_valid = 1'b1;
                drive_en   = 1'b1;
                // ACK every data byte but the last, which gets NACK
                if (int'(byte_cnt) + 2 <= int'(cfg_total)) begin
                    r.shift_value = SV_LOW;
                    byte_cnt      = byte_cnt + 1'b1;
                    phase         = PH_CHECK;
                end else begin
                    r.shift_value = SV_RELEASE;
                    phase         = PH_PREP_STOP;
                end
                r.shift_write = 1'b1;
                r.bit_count   = BITS_ONE;
            end
            PH_PREP_STOP: begin
                drive_en      = 1'b1;
                r.shift_value = SV_LOW;
                r.shift_write = 1'b1;
                r.bit_count   = BITS_ONE;
                phase         = PH_STOP;
            end
            PH_TX_ACK: begin
                drive_en    = 1'b0;
                r.bit_count = BITS_ONE;
                phase       = PH_TX_CHECK;
            end
            PH_TX_CHECK: begin
                drive_en = 1'b1;
                if (byte_cnt == cfg_total) begin
                    r.shift_value = cfg_rs ? SV_RELEASE : SV_LOW;
                    r.shift_write = 1'b1;
                    r.bit_count   = BITS_ONE;
                    phase         = PH_STOP;
                end else begin
                    r.shift_value = pop_tx_byte();
                    r.shift_write = 1'b1;
                    r.bit_count   = BITS_BYTE;
                    byte_cnt      = byte_cnt + 1'b1;
                    phase         = PH_TX_ACK;
                end
            end
            default: begin
                r.shift_value = SV_RELEASE;
                r.shift_write = 1'b1;
                r.bit_count   = BITS_NONE;
                r.stop_pulse  = 1'b1;
                drive_en      = 1'b0;
                r.done_res    = 1'b1;
                phase         = PH_START;
            end
        endcase
        r.sda_output = drive_en;
        return r;
    endfunction

    // Split a result word into its fields
    function automatic t_result unpack_word(logic [OUT_W-1:0] d, logic [OUT_U_W-1:0] u);
        t_result r;
        r.shift_value  = d[7:0];
        r.bit_count    = d[11:8];
        r.sda_output   = d[12];
        r.start_pulse  = d[13];
        r.stop_pulse   = d[14];
        r.rx_byte      = d[22:15];
        r.address_nack = d[23];
        r.done_res     = d[24];
        r.shift_write  = u[0];
        r.rx_valid     = u[1];
        return r;
    endfunction

    // Follow every handshake at the rising edge
    always @(posedge i_clk) begin : track
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_addr  = 8'd66;
            cfg_tx    = 1'b0;
            cfg_total = '0;
            cfg_rs    = 1'b0;
            phase     = PH_START;
            byte_cnt  = '0;
            send_ptr  = '0;
            drive_en  = 1'b0;
            expected_cmds.delete();
        end else begin
            // compare an accepted result word with the oldest expectation
            if (i_m_valid && i_m_ready) begin
                got = unpack_word(i_m_data, i_m_user);
                if (expected_cmds.size() == 0) begin
                    fails++;
                    if (reported < 10) begin
                        reported++;
                        $display("[%0t] unexpected result word %08h user %0h",
                                 $realtime, i_m_data, i_m_user);
                    end
                end else begin
                    want = expected_cmds.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (reported < 10) begin
                            reported++;
                            $display({"[%0t] mismatch exp: sv=%02h sw=%0b bc=%0d sda=%0b",
                                      " st=%0b sp=%0b rx=%02h rv=%0b an=%0b dn=%0b"},
                                     $realtime, want.shift_value, want.shift_write,
                                     want.bit_count, want.sda_output, want.start_pulse,
                                     want.stop_pulse, want.rx_byte, want.rx_valid,
                                     want.address_nack, want.done_res);
                            $display({"             act: sv=%02h sw=%0b bc=%0d sda=%0b",
                                      " st=%0b sp=%0b rx=%02h rv=%0b an=%0b dn=%0b"},
                                     got.shift_value, got.shift_write, got.bit_count,
                                     got.sda_output, got.start_pulse, got.stop_pulse,
                                     got.rx_byte, got.rx_valid, got.address_nack,
                                     got.done_res);
                        end
                    end
                end
            end
            // apply register writes at once
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLAVE_ADDR: cfg_addr  = i_cfg_data;
                    CFG_TX_MODE:    cfg_tx    = i_cfg_data[0];
                    CFG_BYTE_TOTAL: cfg_total = i_cfg_data[CNT_W-1:0];
                    CFG_REP_START:  cfg_rs    = i_cfg_data[0];
                    default: ;
                endcase
            end
            // store a buffer byte or predict the next command
            if (i_s_valid && i_s_ready) begin
                if (i_s_user == OP_STORE)
                    tx_buf[i_s_data[4:0]] = i_s_data[12:5];
                else
                    expected_cmds.push_back(next_command(i_s_data[20:13]));
            end
        end
        o_fail_count = fails;
        o_pending    = expected_cmds.size();
        o_seq_idle   = (phase == PH_START);
    end

endmodule

FILE: tb/tb_i2c_master_byte_sequencer.sv
`timescale 1ns / 100ps
// Testbench top for the I2C master byte sequencer: clock, reset, stimulus and verdict.
module tb_i2c_master_byte_sequencer;
    import i2cmbs_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 250;

    typedef enum int {XF_ACK, XF_CLEAN, XF_NOISY, XF_NACK} t_xfer_mode;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_valid = 1'b0;
    logic [IN_W-1:0]    s_data  = '0;
    logic               s_user  = 1'b0;
    logic               m_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CFG_I_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]  cfg_data  = '0;

    logic               s_ready;
    logic               m_valid;
    logic [OUT_W-1:0]   m_data;
    logic [OUT_U_W-1:0] m_user;
    logic               cfg_ready;

    int   fail_count;
    int   pending;
    logic seq_idle;

    int   items_sent = 0;
    int   cycles     = 0;
    int   stall_ask  = 0;
    bit   no_gaps    = 1'b0;

    i2c_master_byte_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    i2cmbs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_s_user     (s_user),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_m_user     (m_user),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_seq_idle   (seq_idle)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drain side: random ready runs, plus a long hold-off on request
    initial begin : drain
        int run_left;
        int hold_left;
        int stall_seen;
        bit rdy;
        run_left   = 0;
        hold_left  = 0;
        stall_seen = 0;
        rdy        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_ask != stall_seen) begin
                stall_seen = stall_ask;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    rdy = ($urandom_range(99) < 70);
                    if (rdy)
                        run_left = ($urandom_range(9) == 0) ? $urandom_range(300, 100)
                                                            : $urandom_range(30, 1);
                    else
                        run_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                            : $urandom_range(3, 1);
                end
                run_left--;
                m_ready <= rdy;
            end
        end
    end

    // Idle cycles before the next input word: mostly none, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one input word; called and returns at a falling edge
    task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] txd, input logic [BYTE_W-1:0] sin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {3'b000, sin, txd, idx};
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop the input and wait until the block has nothing left in flight
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || !seq_idle) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Write the registers selected in sel, holding valid across back-to-back words
    task automatic program_regs(input logic [BYTE_W-1:0] addr, input logic tx,
                                input logic [CNT_W-1:0] total, input logic rs,
                                input logic [3:0] sel);
        logic [BYTE_W-1:0] vals [4];
        logic [CFG_I_W-1:0] idx [4];
        vals[0] = addr;
        vals[1] = {7'($urandom), tx};
        vals[2] = {2'($urandom), total};
        vals[3] = {7'($urandom), rs};
        idx[0]  = CFG_SLAVE_ADDR;
        idx[1]  = CFG_TX_MODE;
        idx[2]  = CFG_BYTE_TOTAL;
        idx[3]  = CFG_REP_START;
        for (int i = 0; i < 4; i++) begin
            if (sel[i]) begin
                cfg_valid <= 1'b1;
                cfg_index <= idx[i];
                cfg_data  <= vals[i];
                do @(posedge i_clk); while (!cfg_ready);
                @(negedge i_clk);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Feed finish reports until the sequencer is back at its start phase
    task automatic run_transfer(input t_xfer_mode mode);
        logic [BYTE_W-1:0] sin;
        do begin
            // mix buffer stores into clean and noisy transfers
            if ((mode == XF_CLEAN || mode == XF_NOISY) && $urandom_range(99) < 15)
                send_word(OP_STORE, 5'($urandom), 8'($urandom), 8'($urandom));
            // now and then hold the input until every result has come back
            if ($urandom_range(99) < 2) begin
                s_valid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
            end
            sin = 8'($urandom);
            case (mode)
                XF_ACK:   sin[0] = 1'b0;
                XF_CLEAN: sin[0] = ($urandom_range(99) < 3);
                XF_NOISY: sin[0] = sin[0];
                default:  sin[0] = 1'b1;
            endcase
            send_word(OP_FINISH, 5'($urandom), 8'($urandom), sin);
        end while (!seq_idle);
    endtask

    // Pick a byte total: mostly small, a few at the extremes
    function automatic logic [CNT_W-1:0] pick_total();
        int r;
        r = $urandom_range(99);
        if (r < 50) return CNT_W'($urandom_range(4, 1));
        if (r < 62) return '0;
        if (r < 80) return CNT_W'($urandom_range(12, 5));
        if (r < 90) return CNT_W'(32);
        if (r < 95) return CNT_W'(31);
        return CNT_W'($urandom_range(63, 33));
    endfunction

    // Main stimulus
    initial begin : stim
        int          phase_no;
        int          n_xfer;
        int          r;
        logic [3:0]  sel;
        t_xfer_mode  mode;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fill the whole transmit buffer so no transfer reads an empty entry
        for (int i = 0; i < TX_DEPTH_DEF; i++)
            send_word(OP_STORE, 5'(i), (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom),
                      8'($urandom));

        // directed: one write, one read, then an address NACK in each mode
        settle();
        program_regs(8'hFF, 1'b1, 6'd1, 1'b0, 4'b1111);
        run_transfer(XF_ACK);
        settle();
        program_regs(8'h00, 1'b0, 6'd2, 1'b1, 4'b1111);
        run_transfer(XF_ACK);
        settle();
        program_regs(8'h00, 1'b1, 6'd0, 1'b0, 4'b0010);
        run_transfer(XF_NACK);
        settle();
        program_regs(8'h00, 1'b0, 6'd0, 1'b0, 4'b0010);
        run_transfer(XF_NACK);

        // random phases of new settings and a few transfers each
        items_sent = 0;
        phase_no   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            sel = 4'($urandom);
            if (sel == 4'b0000)
                sel = 4'b0100;
            program_regs(8'($urandom), 1'($urandom), pick_total(), 1'($urandom), sel);
            no_gaps = ($urandom_range(4) == 0);
            // hold the drain side off while the sender keeps offering words
            if (phase_no % 6 == 1)
                stall_ask++;
            n_xfer = $urandom_range(3, 1);
            for (int k = 0; k < n_xfer; k++) begin
                r = $urandom_range(99);
                mode = (r < 75) ? XF_CLEAN : (r < 90) ? XF_NOISY : XF_NACK;
                run_transfer(mode);
                // loose store words between transfers
                if ($urandom_range(3) == 0)
                    send_word(OP_STORE, 5'($urandom), 8'($urandom), 8'($urandom));
            end
            phase_no++;
        end

        // drain and give the verdict
        s_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
